>>> hw/rtl/fir_q15_pkg.sv
// ----------------------------------------------------------------------------
// fir_q15_pkg: shared types and constants of the Q15 FIR filter
// Field widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package fir_q15_pkg;

	localparam int FIELD_BITS = 16;
	localparam int ACC_BITS   = 32;
	localparam int INDEX_BITS = 5;

	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_MAC   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

endpackage

>>> hw/rtl/fir_filter_q15_32tap.sv
// ----------------------------------------------------------------------------
// fir_filter_q15_32tap: direct-form FIR filter over Q15 samples
// A filter beat runs from accept to sample_out valid through the single
// multiply-accumulate unit that walks one tap per cycle plus a two-stage
// product pipe; the input stalls until the result is handed to the
// output register, so a new filter beat is not taken before the last
// is through. Reset clears the delay line, the coefficient valid bits
// and all control state.
// ----------------------------------------------------------------------------
module fir_filter_q15_32tap #(
	parameter int TAPS        = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_stall,
	input  logic                                         operation,
	input  logic signed [fir_q15_pkg::FIELD_BITS-1:0]    sample_in,
	input  logic        [fir_q15_pkg::INDEX_BITS-1:0]    tap_index,
	input  logic signed [fir_q15_pkg::FIELD_BITS-1:0]    tap_value,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic signed [fir_q15_pkg::FIELD_BITS-1:0]    sample_out
);

	localparam int ADDR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int SB     = SAMPLE_BITS;
	localparam int ACC_W  = fir_q15_pkg::ACC_BITS;

	fir_q15_pkg::state_t state_q;

	logic [ADDR_W-1:0]      cnt_q;
	logic signed [SB-1:0]   ring_q [TAPS];
	logic [TAPS-1:0]        coef_vld_q;
	logic signed [SB-1:0]   coef_mem_q [TAPS];

	logic signed [SB-1:0]   sample_s1;
	logic signed [SB-1:0]   coef_s1;
	logic                   cvld_s1;
	logic                   vld_s1;
	logic [ACC_W-1:0]       prod_s2;
	logic                   vld_s2;
	logic [ACC_W-1:0]       acc_q;

	logic                   out_vld_q;
	logic signed [fir_q15_pkg::FIELD_BITS-1:0] out_q;

	logic                   in_fire;
	logic                   filter_fire;
	logic                   coef_fire;
	logic                   coef_in_range;
	logic                   pipe_empty;
	logic                   out_free;
	logic signed [SB-1:0]   coef_eff;
	logic signed [2*SB-1:0] prod;

	assign in_stall      = (state_q != fir_q15_pkg::ST_IDLE);
	assign in_fire       = in_valid && !in_stall;
	assign filter_fire   = in_fire && (operation == fir_q15_pkg::OP_FILTER);
	assign coef_fire     = in_fire && (operation == fir_q15_pkg::OP_COEF);
	assign coef_in_range = (9'(tap_index) < 9'(TAPS));
	assign pipe_empty    = !vld_s1 && !vld_s2;
	assign out_free      = !out_vld_q || !out_stall;

	assign coef_eff = cvld_s1 ? coef_s1 : '0;
	assign prod     = (2*SB)'(sample_s1) * (2*SB)'(coef_eff);

	assign out_valid  = out_vld_q;
	assign sample_out = out_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fir_q15_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				fir_q15_pkg::ST_IDLE: begin
					if (filter_fire) begin
						state_q <= fir_q15_pkg::ST_MAC;
						cnt_q   <= '0;
					end
				end
				fir_q15_pkg::ST_MAC: begin
					if (cnt_q == ADDR_W'(TAPS - 1)) begin
						state_q <= fir_q15_pkg::ST_DRAIN;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				fir_q15_pkg::ST_DRAIN: begin
					if (pipe_empty && out_free) begin
						state_q <= fir_q15_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fir_q15_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// delay line as a ring: shift in on accept, rotate once per tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				ring_q[k] <= '0;
			end
		end else if (filter_fire) begin
			for (int k = TAPS - 1; k > 0; k--) begin
				ring_q[k] <= ring_q[k-1];
			end
			ring_q[0] <= SB'($unsigned(sample_in));
		end else if (state_q == fir_q15_pkg::ST_MAC) begin
			for (int k = 0; k < TAPS - 1; k++) begin
				ring_q[k] <= ring_q[k+1];
			end
			ring_q[TAPS-1] <= ring_q[0];
		end
	end

	// coefficient valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (coef_fire && coef_in_range) begin
			coef_vld_q[ADDR_W'(tap_index)] <= 1'b1;
		end
	end

	// coefficient memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (coef_fire && coef_in_range) begin
			coef_mem_q[ADDR_W'(tap_index)] <= SB'($unsigned(tap_value));
		end
		coef_s1   <= coef_mem_q[cnt_q];
		sample_s1 <= ring_q[0];
	end

	// product and accumulate pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			cvld_s1 <= 1'b0;
		end else begin
			vld_s1  <= (state_q == fir_q15_pkg::ST_MAC);
			vld_s2  <= vld_s1;
			cvld_s1 <= coef_vld_q[cnt_q];
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ACC_W'(prod);
		if (filter_fire) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + {prod_s2[ACC_W-2:0], 1'b0};
		end
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == fir_q15_pkg::ST_DRAIN && pipe_empty && out_free) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fir_q15_pkg::ST_DRAIN && pipe_empty && out_free) begin
			out_q <= acc_q[ACC_W-1 -: fir_q15_pkg::FIELD_BITS];
		end
	end

endmodule
